// File: hdl/text_console_cell_writer_top_defines.svh
// Assertion macros shared by the console cell writer modules.
// Each macro expects signals named clk and rst in the using module.
`ifndef TEXT_CONSOLE_CELL_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define TCCW_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that forces a consequence in the same cycle.
`define TCCW_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that forces a consequence in the next cycle.
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// No dependencies; used by every module of the block except tccw_ram.
package tccw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths of the item and result ports.
  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int DATA_W    = 16;
  localparam int POS_W     = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int ATTR_W    = 8;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 2;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // Character codes and cell constants.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  // Operations decoded by the front part.
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_NONE
  } op_t;

  // One classified command in the queue.
  typedef struct packed {
    op_t                op;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } cmd_t;

  // Handshake from the back part to the front part.
  typedef struct packed {
    logic take;
    logic init_busy;
  } back_status_t;

  // Back part sequencer states.
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN
  } state_t;

endpackage

// File: hdl/tccw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tccw_front.sv
// Front part: classifies input items into commands and queues them.
// Depends on tccw_pkg and the assertion macro header.
`include "text_console_cell_writer_top_defines.svh"

module tccw_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [tccw_pkg::KIND_W-1:0]    kind,
  input  logic [tccw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tccw_pkg::INDEX_W-1:0]   cell_index,
  output logic                           cmd_valid,
  output tccw_pkg::cmd_t                 cmd,
  input  tccw_pkg::back_status_t         status
);

  localparam int AW = $clog2(tccw_pkg::CMD_DEPTH);

  tccw_pkg::cmd_t queue [tccw_pkg::CMD_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  tccw_pkg::cmd_t classified;
  logic           accept;

  // Decode the item kind and control characters into an operation.
  always_comb begin
    classified.char_code  = char_code;
    classified.cell_index = cell_index;
    unique case (kind)
      tccw_pkg::KIND_PUT: begin
        if (char_code == tccw_pkg::CH_NEWLINE) begin
          classified.op = tccw_pkg::OP_NEWLINE;
        end else if (char_code == tccw_pkg::CH_RETURN) begin
          classified.op = tccw_pkg::OP_RETURN;
        end else if (char_code == tccw_pkg::CH_BACKSPACE) begin
          classified.op = tccw_pkg::OP_BACKSPACE;
        end else begin
          classified.op = tccw_pkg::OP_PUT;
        end
      end
      tccw_pkg::KIND_CLEAR: classified.op = tccw_pkg::OP_CLEAR;
      tccw_pkg::KIND_READ:  classified.op = tccw_pkg::OP_READ;
      tccw_pkg::KIND_NONE:  classified.op = tccw_pkg::OP_NONE;
      default:              classified.op = tccw_pkg::OP_NONE;
    endcase
  end

  // No item is taken while the screen store is being cleared after reset.
  assign full      = (count == (AW+1)'(tccw_pkg::CMD_DEPTH)) || status.init_busy;
  assign accept    = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= classified;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == AW'(tccw_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (status.take) begin
        rd_ptr <= (rd_ptr == AW'(tccw_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (accept && !status.take) begin
        count <= count + 1'b1;
      end else if (!accept && status.take) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue consistency checks.
  `TCCW_ASSERT_HOLDS(a_count_range, count <= (AW+1)'(tccw_pkg::CMD_DEPTH), "command queue overfilled")
  `TCCW_ASSERT_IMPLIES(a_take_nonempty, status.take, cmd_valid, "command taken from an empty queue")
  `TCCW_ASSERT_NEXT(a_push_fills, accept && !status.take, cmd_valid, "accepted transaction lost in queue")

endmodule

// File: hdl/tccw_back.sv
// Back part: executes queued commands against the screen store and holds the result.
// Depends on tccw_pkg, tccw_ram and the assertion macro header.
`include "text_console_cell_writer_top_defines.svh"

module tccw_back #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  tccw_pkg::cmd_t                  cmd,
  output tccw_pkg::back_status_t          status,
  input  logic                            cfg_write,
  input  logic [tccw_pkg::ATTR_W-1:0]     cfg_data,
  output logic                            empty,
  input  logic                            pop,
  output logic [tccw_pkg::DATA_W-1:0]     read_data,
  output logic [tccw_pkg::POS_W-1:0]      cursor_pos,
  output logic [tccw_pkg::COL_OUT_W-1:0]  cursor_col,
  output logic [tccw_pkg::ROW_OUT_W-1:0]  cursor_row,
  output logic                            scrolled
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] SECOND_ROW    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);

  tccw_pkg::state_t state, state_next;

  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ADDR_W-1:0] scan, scan_next;
  logic [tccw_pkg::ATTR_W-1:0] text_attribute;
  logic [tccw_pkg::ATTR_W-1:0] sweep_attr, sweep_attr_next;
  logic sweep_init, sweep_init_next;
  logic scroll_flag, scroll_flag_next;
  logic pipe_valid, pipe_valid_next;
  logic [ADDR_W-1:0] pipe_addr, pipe_addr_next;

  logic                        res_valid;
  logic [tccw_pkg::DATA_W-1:0] res_data, res_data_next;
  logic [COL_W-1:0]            res_col;
  logic [ROW_W-1:0]            res_row;
  logic                        res_scrolled;
  logic                        load_res;

  logic                        take;
  logic                        read_in_range;
  logic [COL_W-1:0]            bs_col;
  logic [ROW_W-1:0]            bs_row;
  logic [COL_W-1:0]            sel_col;
  logic [ROW_W-1:0]            sel_row;
  logic [ADDR_W-1:0]           cursor_addr;
  logic [ADDR_W-1:0]           res_addr;

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [tccw_pkg::DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [tccw_pkg::DATA_W-1:0] ram_rdata;

  // Screen store.
  tccw_ram #(
    .WIDTH(tccw_pkg::DATA_W),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A command starts only when the result slot is free or being emptied.
  assign take = cmd_valid && (state == tccw_pkg::ST_IDLE) && (!res_valid || pop);
  assign status.take      = take;
  assign status.init_busy = sweep_init;

  assign read_in_range = 32'(cmd.cell_index) < 32'(CELL_COUNT);

  // Cursor position after a backspace.
  always_comb begin
    bs_col = col;
    bs_row = row;
    if (col != '0) begin
      bs_col = col - 1'b1;
    end else if (row != '0) begin
      bs_row = row - 1'b1;
      bs_col = LAST_COL;
    end
  end

  // Address of the cell that a character or backspace writes.
  assign sel_col     = (cmd.op == tccw_pkg::OP_BACKSPACE) ? bs_col : col;
  assign sel_row     = (cmd.op == tccw_pkg::OP_BACKSPACE) ? bs_row : row;
  assign cursor_addr = ADDR_W'(sel_row) * ADDR_W'(COLUMNS) + ADDR_W'(sel_col);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      tccw_pkg::ST_SWEEP: begin
        if (scan == LAST_CELL) begin
          state_next = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_SCROLL: begin
        if (scan == LAST_CELL) begin
          state_next = tccw_pkg::ST_DRAIN;
        end
      end
      tccw_pkg::ST_DRAIN: state_next = tccw_pkg::ST_SWEEP;
      tccw_pkg::ST_READ:  state_next = tccw_pkg::ST_IDLE;
      tccw_pkg::ST_IDLE: begin
        if (take) begin
          unique case (cmd.op)
            tccw_pkg::OP_PUT: begin
              if (col == LAST_COL && row == LAST_ROW) begin
                state_next = tccw_pkg::ST_SCROLL;
              end
            end
            tccw_pkg::OP_NEWLINE: begin
              if (row == LAST_ROW) begin
                state_next = tccw_pkg::ST_SCROLL;
              end
            end
            tccw_pkg::OP_CLEAR: state_next = tccw_pkg::ST_SWEEP;
            tccw_pkg::OP_READ: begin
              if (read_in_range) begin
                state_next = tccw_pkg::ST_READ;
              end
            end
            tccw_pkg::OP_RETURN,
            tccw_pkg::OP_BACKSPACE,
            tccw_pkg::OP_NONE: state_next = tccw_pkg::ST_IDLE;
            default: state_next = tccw_pkg::ST_IDLE;
          endcase
        end
      end
      default: state_next = tccw_pkg::ST_IDLE;
    endcase
  end

  // Datapath control: store accesses, cursor updates and result loading.
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = cursor_addr;
    ram_wdata        = {text_attribute, tccw_pkg::BLANK_CHAR};
    ram_raddr        = scan;
    col_next         = col;
    row_next         = row;
    scan_next        = scan;
    sweep_attr_next  = sweep_attr;
    sweep_init_next  = sweep_init;
    scroll_flag_next = scroll_flag;
    pipe_valid_next  = pipe_valid;
    pipe_addr_next   = pipe_addr;
    load_res         = 1'b0;
    res_data_next    = '0;
    unique case (state)
      tccw_pkg::ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = scan;
        ram_wdata = {sweep_attr, tccw_pkg::BLANK_CHAR};
        scan_next = scan + 1'b1;
        if (scan == LAST_CELL) begin
          sweep_init_next = 1'b0;
          load_res        = !sweep_init;
        end
      end
      tccw_pkg::ST_SCROLL: begin
        // Read one row ahead and write the word read in the previous cycle.
        ram_raddr       = scan;
        ram_we          = pipe_valid;
        ram_waddr       = pipe_addr;
        ram_wdata       = ram_rdata;
        pipe_valid_next = 1'b1;
        pipe_addr_next  = scan - SECOND_ROW;
        scan_next       = (scan == LAST_CELL) ? LAST_ROW_BASE : scan + 1'b1;
      end
      tccw_pkg::ST_DRAIN: begin
        ram_we          = 1'b1;
        ram_waddr       = pipe_addr;
        ram_wdata       = ram_rdata;
        pipe_valid_next = 1'b0;
      end
      tccw_pkg::ST_READ: begin
        load_res      = 1'b1;
        res_data_next = ram_rdata;
      end
      tccw_pkg::ST_IDLE: begin
        if (take) begin
          scroll_flag_next = 1'b0;
          pipe_valid_next  = 1'b0;
          unique case (cmd.op)
            tccw_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_wdata = {text_attribute, cmd.char_code};
              if (col == LAST_COL) begin
                col_next = '0;
                if (row == LAST_ROW) begin
                  scroll_flag_next = 1'b1;
                  sweep_attr_next  = text_attribute;
                  scan_next        = SECOND_ROW;
                end else begin
                  row_next = row + 1'b1;
                  load_res = 1'b1;
                end
              end else begin
                col_next = col + 1'b1;
                load_res = 1'b1;
              end
            end
            tccw_pkg::OP_NEWLINE: begin
              col_next = '0;
              if (row == LAST_ROW) begin
                scroll_flag_next = 1'b1;
                sweep_attr_next  = text_attribute;
                scan_next        = SECOND_ROW;
              end else begin
                row_next = row + 1'b1;
                load_res = 1'b1;
              end
            end
            tccw_pkg::OP_RETURN: begin
              col_next = '0;
              load_res = 1'b1;
            end
            tccw_pkg::OP_BACKSPACE: begin
              ram_we   = 1'b1;
              col_next = bs_col;
              row_next = bs_row;
              load_res = 1'b1;
            end
            tccw_pkg::OP_CLEAR: begin
              col_next        = '0;
              row_next        = '0;
              scan_next       = '0;
              sweep_attr_next = text_attribute;
            end
            tccw_pkg::OP_READ: begin
              ram_raddr = ADDR_W'(cmd.cell_index);
              load_res  = !read_in_range;
            end
            tccw_pkg::OP_NONE: load_res = 1'b1;
            default:           load_res = 1'b1;
          endcase
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer and cursor registers; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tccw_pkg::ST_SWEEP;
      col            <= '0;
      row            <= '0;
      scan           <= '0;
      sweep_attr     <= tccw_pkg::RESET_ATTR;
      sweep_init     <= 1'b1;
      scroll_flag    <= 1'b0;
      pipe_valid     <= 1'b0;
      text_attribute <= tccw_pkg::RESET_ATTR;
    end else begin
      state       <= state_next;
      col         <= col_next;
      row         <= row_next;
      scan        <= scan_next;
      sweep_attr  <= sweep_attr_next;
      sweep_init  <= sweep_init_next;
      scroll_flag <= scroll_flag_next;
      pipe_valid  <= pipe_valid_next;
      if (cfg_write) begin
        text_attribute <= cfg_data;
      end
    end
  end

  // Copy pipeline address.
  always_ff @(posedge clk) begin
    pipe_addr <= pipe_addr_next;
  end

  // Result slot valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_data     <= res_data_next;
      res_col      <= col_next;
      res_row      <= row_next;
      res_scrolled <= scroll_flag_next;
    end
  end

  // Result ports.
  assign res_addr   = ADDR_W'(res_row) * ADDR_W'(COLUMNS) + ADDR_W'(res_col);
  assign empty      = !res_valid;
  assign read_data  = res_data;
  assign cursor_pos = tccw_pkg::POS_W'(res_addr);
  assign cursor_col = tccw_pkg::COL_OUT_W'(res_col);
  assign cursor_row = tccw_pkg::ROW_OUT_W'(res_row);
  assign scrolled   = res_scrolled;

  // Sequencer and cursor checks.
  `TCCW_ASSERT_HOLDS(a_cursor_range, (col <= LAST_COL) && (row <= LAST_ROW), "cursor out of screen")
  `TCCW_ASSERT_IMPLIES(a_scroll_cursor, state == tccw_pkg::ST_SCROLL, (row == LAST_ROW) && (col == '0), "scroll with cursor off the bottom row start")
  `TCCW_ASSERT_NEXT(a_read_result, state == tccw_pkg::ST_READ, res_valid, "cell read produced no result")
  `TCCW_ASSERT_IMPLIES(a_no_overwrite, load_res, !res_valid || pop, "result slot overwritten")

endmodule

// File: hdl/text_console_cell_writer_top.sv
// Text console cell writer top: front classifier and command queue, back executor with store.
// Depends on tccw_pkg, tccw_front, tccw_back and tccw_ram.
// Accept to result: the queue, then the result for characters and no-op kinds; an in-range
// read adds the read state, a clear a sweep of all cells, a scroll a copy at one cell per
// cycle, a drain and a bottom-row sweep. One item per cycle while idle and results are popped.
// Reset: synchronous; a pass over every cell blanks the store with 0x0F while full is high.
module text_console_cell_writer_top #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [tccw_pkg::KIND_W-1:0]     kind,
  input  logic [tccw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tccw_pkg::INDEX_W-1:0]    cell_index,
  output logic                            empty,
  input  logic                            pop,
  output logic [tccw_pkg::DATA_W-1:0]     read_data,
  output logic [tccw_pkg::POS_W-1:0]      cursor_pos,
  output logic [tccw_pkg::COL_OUT_W-1:0]  cursor_col,
  output logic [tccw_pkg::ROW_OUT_W-1:0]  cursor_row,
  output logic                            scrolled,
  input  logic                            cfg_write,
  input  logic [tccw_pkg::ATTR_W-1:0]     cfg_data
);

  logic                   cmd_valid;
  tccw_pkg::cmd_t         cmd;
  tccw_pkg::back_status_t status;

  // Front part: classification and command queue.
  tccw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .char_code  (char_code),
    .cell_index (cell_index),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .status     (status)
  );

  // Back part: execution against the screen store.
  tccw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .empty      (empty),
    .pop        (pop),
    .read_data  (read_data),
    .cursor_pos (cursor_pos),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

endmodule
